// ----- sv/lsf_pkg.sv -----
// Shared widths, codes and unit command types for the line-fit core.
// No dependencies; used by lsf_mdu and least_squares_line_fit_core.
`default_nettype none

package lsf_pkg;

    // Data set capacity and sample size
    localparam int MAX_POINTS  = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 16;
    localparam int Q_W         = 32;

    // Exact running sum widths
    localparam int LOG_PTS = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SX_W    = SAMPLE_BITS + LOG_PTS;         // signed
    localparam int SXX_W   = 2 * SAMPLE_BITS + LOG_PTS - 1; // unsigned
    localparam int SXY_W   = SXX_W + 1;                     // signed

    // Multiply/divide unit widths
    localparam int MA_W   = SXY_W;               // multiplicand, signed
    localparam int MB_W   = SX_W;                // multiplier, signed, one bit a step
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = PROD_W + 1;          // accumulator, signed
    localparam int ADD_W  = ACC_W + 2;           // shared adder
    localparam int NUM_W  = ACC_W - 1 + FRAC_BITS; // scaled dividend magnitude
    localparam int QX_W   = Q_W + 1;             // quotient window
    localparam int STEP_W = $clog2(NUM_W);

    typedef enum logic {
        MODE_MUL = 1'b0,
        MODE_DIV = 1'b1
    } t_mdu_mode;

    // Result status, lowest applicable code reported
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_DEN  = 2'd1,
        ST_DROPPED   = 2'd2,
        ST_SATURATED = 2'd3
    } t_fit_status;

    // Command to the unit: acc = opnd +/- a*b, or quo = opnd * 2^16 / den
    typedef struct packed {
        logic             go;
        t_mdu_mode        mode;
        logic             neg;
        logic [ACC_W-1:0] opnd;
        logic [MA_W-1:0]  a;
        logic [MB_W-1:0]  b;
        logic [ACC_W-1:0] den;
    } t_mdu_cmd;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic             sat;
        logic [ACC_W-1:0] acc;
        logic [Q_W-1:0]   quo;
    } t_mdu_rsp;

endpackage

`default_nettype wire

// ----- sv/lsf_mdu.sv -----
// Iterative multiply-accumulate / fixed-point divide unit around one adder.
// Depends on lsf_pkg for widths and the command/response structs.
`default_nettype none

module lsf_mdu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lsf_pkg::t_mdu_cmd i_cmd,
    output lsf_pkg::t_mdu_rsp      o_rsp
);
    import lsf_pkg::*;

    typedef enum logic [3:0] {
        U_IDLE = 4'b0001,
        U_MUL  = 4'b0010,
        U_DIV  = 4'b0100,
        U_FIN  = 4'b1000
    } t_ustate;

    localparam logic [QX_W-1:0] Q_LIM_POS = {2'b00, {(Q_W-1){1'b1}}};
    localparam logic [QX_W-1:0] Q_LIM_NEG = {2'b01, {(Q_W-1){1'b0}}};

    t_ustate             r_state, n_state;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [ACC_W-1:0]    r_acc;
    logic [PROD_W-1:0]   r_ash;
    logic [MB_W-1:0]     r_b;
    logic [ACC_W-1:0]    r_den;
    logic [NUM_W-1:0]    r_num;
    logic [QX_W-1:0]     r_q;
    logic                r_ovf;
    logic                r_neg;
    logic [Q_W-1:0]      r_quo;
    logic                r_sat;

    logic [ADD_W-1:0]    w_opa, w_opb, w_sum;
    logic                w_sub;
    logic [ACC_W:0]      w_shift;
    logic                w_qbit;
    logic                w_last_mul;
    logic                w_last_div;
    logic [QX_W-1:0]     w_lim;
    logic                w_fin_sat;
    logic [QX_W-1:0]     w_fin_mag;
    logic [ACC_W-1:0]    w_mag;

    // Step decode
    assign w_shift    = {r_acc, r_num[NUM_W-1]};
    assign w_last_mul = (r_cnt == STEP_W'(MB_W - 1));
    assign w_last_div = (r_cnt == STEP_W'(NUM_W - 1));
    assign w_lim      = r_neg ? Q_LIM_NEG : Q_LIM_POS;
    assign w_fin_sat  = r_ovf || (r_q > w_lim);
    assign w_fin_mag  = w_fin_sat ? w_lim : r_q;

    // Operand select for the shared adder
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        w_sub = 1'b0;
        case (r_state)
            U_IDLE: begin
                // dividend magnitude at start of a divide
                w_opb = {{(ADD_W-ACC_W){i_cmd.opnd[ACC_W-1]}}, i_cmd.opnd};
                w_sub = 1'b1;
            end
            U_MUL: begin
                // sign bit of the multiplier carries negative weight
                w_opa = {{(ADD_W-ACC_W){r_acc[ACC_W-1]}}, r_acc};
                w_opb = {{(ADD_W-PROD_W){r_ash[PROD_W-1]}}, r_ash};
                w_sub = r_neg ^ w_last_mul;
            end
            U_DIV: begin
                w_opa = {{(ADD_W-ACC_W-1){1'b0}}, w_shift};
                w_opb = {{(ADD_W-ACC_W){1'b0}}, r_den};
                w_sub = 1'b1;
            end
            U_FIN: begin
                w_opb = {{(ADD_W-QX_W){1'b0}}, w_fin_mag};
                w_sub = 1'b1;
            end
            default: begin
                w_opa = '0;
            end
        endcase
    end

    assign w_sum  = w_opa + (w_sub ? ~w_opb : w_opb) + {{(ADD_W-1){1'b0}}, w_sub};
    assign w_qbit = ~w_sum[ADD_W-1];
    assign w_mag  = i_cmd.opnd[ACC_W-1] ? w_sum[ACC_W-1:0] : i_cmd.opnd;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE: begin
                if (i_cmd.go) begin
                    n_state = (i_cmd.mode == MODE_DIV) ? U_DIV : U_MUL;
                end
            end
            U_MUL: begin
                if (w_last_mul) begin
                    n_state = U_IDLE;
                end
            end
            U_DIV: begin
                if (w_last_div) begin
                    n_state = U_FIN;
                end
            end
            U_FIN: begin
                n_state = U_IDLE;
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= ((r_state == U_MUL) && w_last_mul) || (r_state == U_FIN);
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE: begin
                if (i_cmd.go) begin
                    r_cnt <= '0;
                    if (i_cmd.mode == MODE_DIV) begin
                        r_acc <= '0;
                        r_den <= i_cmd.den;
                        r_neg <= i_cmd.opnd[ACC_W-1];
                        r_num <= {w_mag[ACC_W-2:0], {FRAC_BITS{1'b0}}};
                        r_q   <= '0;
                        r_ovf <= 1'b0;
                    end else begin
                        r_acc <= i_cmd.opnd;
                        r_ash <= {{(PROD_W-MA_W){i_cmd.a[MA_W-1]}}, i_cmd.a};
                        r_b   <= i_cmd.b;
                        r_neg <= i_cmd.neg;
                    end
                end
            end
            U_MUL: begin
                if (r_b[0]) begin
                    r_acc <= w_sum[ACC_W-1:0];
                end
                r_ash <= r_ash << 1;
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + STEP_W'(1);
            end
            U_DIV: begin
                // restoring step, quotient window tracks overflow
                r_acc <= w_qbit ? w_sum[ACC_W-1:0] : w_shift[ACC_W-1:0];
                r_num <= r_num << 1;
                r_q   <= {r_q[QX_W-2:0], w_qbit};
                r_ovf <= r_ovf | r_q[QX_W-1];
                r_cnt <= r_cnt + STEP_W'(1);
            end
            U_FIN: begin
                r_quo <= r_neg ? w_sum[Q_W-1:0] : w_fin_mag[Q_W-1:0];
                r_sat <= w_fin_sat;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_rsp.busy = (r_state != U_IDLE);
    assign o_rsp.done = r_done;
    assign o_rsp.sat  = r_sat;
    assign o_rsp.acc  = r_acc;
    assign o_rsp.quo  = r_quo;

endmodule

`default_nettype wire

// ----- sv/least_squares_line_fit_core.sv -----
// Least-squares line fit core: point accumulation, fit sequencing, output register.
// Depends on lsf_pkg and lsf_mdu.
`default_nettype none

// Each input item is one signed (x, y) point; the core keeps exact sums of
// count, x, y, x*x and x*y and, on the item marked last, returns one result
// item with slope and intercept in signed Q16.16 (truncated toward zero,
// saturated), the point count and a status code, then clears the sums.
// All products and quotients go through one shift-add multiply / restoring
// divide unit that retires one bit per cycle. The core takes no new point until
// it has run the two multiply-accumulates of 28 steps each for x*x and x*y. A
// last point adds six multiply-accumulates for the numerators and the
// denominator, two divisions of 88 steps each, and the load of the output
// register (no division runs when the denominator is zero or negative). That
// load also waits while the previous result is still held. Up to 4096
// points per set; further points are not summed and set the dropped flag.
// A finished result waits in the output register while the next set starts.
module least_squares_line_fit_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [lsf_pkg::SAMPLE_BITS-1:0] i_x_value,
    input  wire logic signed [lsf_pkg::SAMPLE_BITS-1:0] i_y_value,
    input  wire logic                                i_last_point,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [lsf_pkg::Q_W-1:0]           o_fit_slope,
    output logic signed [lsf_pkg::Q_W-1:0]           o_fit_intercept,
    output logic [lsf_pkg::CNT_W-1:0]                o_points_used,
    output logic [1:0]                               o_fit_status
);
    import lsf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PT_XX = 7'b0000010,
        S_PT_XY = 7'b0000100,
        S_FIT   = 7'b0001000,
        S_DIV_S = 7'b0010000,
        S_DIV_I = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    typedef enum logic [2:0] {
        OP_DEN_A = 3'd0,
        OP_DEN_B = 3'd1,
        OP_SLP_A = 3'd2,
        OP_SLP_B = 3'd3,
        OP_ICP_A = 3'd4,
        OP_ICP_B = 3'd5
    } t_fit_op;

    t_state                  r_state;
    t_fit_op                 r_op;
    logic                    r_wait;
    logic                    r_o_valid;
    logic [CNT_W-1:0]        r_count;
    logic [SX_W-1:0]         r_sum_x;
    logic [SX_W-1:0]         r_sum_y;
    logic [SXX_W-1:0]        r_sum_xx;
    logic [SXY_W-1:0]        r_sum_xy;
    logic                    r_dropped;

    logic [SAMPLE_BITS-1:0]  r_x;
    logic [SAMPLE_BITS-1:0]  r_y;
    logic                    r_last;
    logic [ACC_W-1:0]        r_den;
    logic [ACC_W-1:0]        r_nums;
    logic [ACC_W-1:0]        r_numi;
    logic                    r_sat;
    logic [Q_W-1:0]          r_slope;
    logic [Q_W-1:0]          r_icpt;
    t_fit_status             r_status;
    logic [Q_W-1:0]          r_o_slope;
    logic [Q_W-1:0]          r_o_icpt;
    logic [CNT_W-1:0]        r_o_count;
    t_fit_status             r_o_status;

    logic                    w_accept;
    logic                    w_room;
    logic                    w_done;
    logic                    w_den_bad;
    logic                    w_out_free;
    t_mdu_cmd                w_cmd;
    t_mdu_rsp                w_rsp;

    // Operand views
    logic [MA_W-1:0]         w_x_a, w_sx_a, w_sy_a, w_sxx_a, w_sxy_a;
    logic [MB_W-1:0]         w_x_b, w_y_b, w_sx_b, w_sy_b, w_n_b;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid && o_ready;
    assign w_room     = (r_count < CNT_W'(MAX_POINTS));
    assign w_done     = r_wait && w_rsp.done;
    assign w_den_bad  = r_den[ACC_W-1] || (r_den == '0);
    assign w_out_free = !r_o_valid || i_ready;

    assign w_x_a   = {{(MA_W-SAMPLE_BITS){r_x[SAMPLE_BITS-1]}}, r_x};
    assign w_sx_a  = {{(MA_W-SX_W){r_sum_x[SX_W-1]}}, r_sum_x};
    assign w_sy_a  = {{(MA_W-SX_W){r_sum_y[SX_W-1]}}, r_sum_y};
    assign w_sxx_a = {{(MA_W-SXX_W){1'b0}}, r_sum_xx};
    assign w_sxy_a = r_sum_xy;
    assign w_x_b   = {{(MB_W-SAMPLE_BITS){r_x[SAMPLE_BITS-1]}}, r_x};
    assign w_y_b   = {{(MB_W-SAMPLE_BITS){r_y[SAMPLE_BITS-1]}}, r_y};
    assign w_sx_b  = r_sum_x;
    assign w_sy_b  = r_sum_y;
    assign w_n_b   = {{(MB_W-CNT_W){1'b0}}, r_count};

    // Command to the shared unit, one go per step
    always_comb begin
        w_cmd      = '0;
        w_cmd.go   = 1'b0;
        w_cmd.mode = MODE_MUL;
        case (r_state)
            S_PT_XX: begin
                w_cmd.go   = !r_wait;
                w_cmd.opnd = {{(ACC_W-SXX_W){1'b0}}, r_sum_xx};
                w_cmd.a    = w_x_a;
                w_cmd.b    = w_x_b;
            end
            S_PT_XY: begin
                w_cmd.go   = !r_wait;
                w_cmd.opnd = {{(ACC_W-SXY_W){r_sum_xy[SXY_W-1]}}, r_sum_xy};
                w_cmd.a    = w_x_a;
                w_cmd.b    = w_y_b;
            end
            S_FIT: begin
                w_cmd.go = !r_wait;
                case (r_op)
                    OP_DEN_A: begin
                        w_cmd.a = w_sxx_a;
                        w_cmd.b = w_n_b;
                    end
                    OP_DEN_B: begin
                        w_cmd.opnd = r_den;
                        w_cmd.neg  = 1'b1;
                        w_cmd.a    = w_sx_a;
                        w_cmd.b    = w_sx_b;
                    end
                    OP_SLP_A: begin
                        w_cmd.a = w_sxy_a;
                        w_cmd.b = w_n_b;
                    end
                    OP_SLP_B: begin
                        w_cmd.opnd = r_nums;
                        w_cmd.neg  = 1'b1;
                        w_cmd.a    = w_sy_a;
                        w_cmd.b    = w_sx_b;
                    end
                    OP_ICP_A: begin
                        w_cmd.a = w_sxx_a;
                        w_cmd.b = w_sy_b;
                    end
                    OP_ICP_B: begin
                        w_cmd.opnd = r_numi;
                        w_cmd.neg  = 1'b1;
                        w_cmd.a    = w_sxy_a;
                        w_cmd.b    = w_sx_b;
                    end
                    default: begin
                        w_cmd.go = 1'b0;
                    end
                endcase
            end
            S_DIV_S: begin
                w_cmd.go   = !r_wait;
                w_cmd.mode = MODE_DIV;
                w_cmd.opnd = r_nums;
                w_cmd.den  = r_den;
            end
            S_DIV_I: begin
                w_cmd.go   = !r_wait;
                w_cmd.mode = MODE_DIV;
                w_cmd.opnd = r_numi;
                w_cmd.den  = r_den;
            end
            default: begin
                w_cmd.go = 1'b0;
            end
        endcase
    end

    lsf_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_rsp   (w_rsp)
    );

    // Sequencer, running sums and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_op      <= OP_DEN_A;
            r_wait    <= 1'b0;
            r_o_valid <= 1'b0;
            r_count   <= '0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_sum_xx  <= '0;
            r_sum_xy  <= '0;
            r_dropped <= 1'b0;
        end else begin
            if (w_cmd.go) begin
                r_wait <= 1'b1;
            end else if (w_done) begin
                r_wait <= 1'b0;
            end
            // a new result loads as the held one leaves
            if ((r_state == S_OUT) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op <= OP_DEN_A;
                        if (w_room) begin
                            r_count <= r_count + CNT_W'(1);
                            r_sum_x <= r_sum_x +
                                {{(SX_W-SAMPLE_BITS){i_x_value[SAMPLE_BITS-1]}}, i_x_value};
                            r_sum_y <= r_sum_y +
                                {{(SX_W-SAMPLE_BITS){i_y_value[SAMPLE_BITS-1]}}, i_y_value};
                            r_state <= S_PT_XX;
                        end else begin
                            // capacity full: point accepted but not summed
                            r_dropped <= 1'b1;
                            r_state   <= i_last_point ? S_FIT : S_IDLE;
                        end
                    end
                end
                S_PT_XX: begin
                    if (w_done) begin
                        r_sum_xx <= w_rsp.acc[SXX_W-1:0];
                        r_state  <= S_PT_XY;
                    end
                end
                S_PT_XY: begin
                    if (w_done) begin
                        r_sum_xy <= w_rsp.acc[SXY_W-1:0];
                        r_state  <= r_last ? S_FIT : S_IDLE;
                    end
                end
                S_FIT: begin
                    if (w_done) begin
                        if (r_op == OP_ICP_B) begin
                            r_state <= w_den_bad ? S_OUT : S_DIV_S;
                        end else begin
                            r_op <= t_fit_op'(r_op + 3'd1);
                        end
                    end
                end
                S_DIV_S: begin
                    if (w_done) begin
                        r_state <= S_DIV_I;
                    end
                end
                S_DIV_I: begin
                    if (w_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_count   <= '0;
                        r_sum_x   <= '0;
                        r_sum_y   <= '0;
                        r_sum_xx  <= '0;
                        r_sum_xy  <= '0;
                        r_dropped <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Item capture, fit terms and result registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_x    <= i_x_value;
                    r_y    <= i_y_value;
                    r_last <= i_last_point;
                end
            end
            S_FIT: begin
                if (w_done) begin
                    case (r_op)
                        OP_DEN_A, OP_DEN_B: r_den  <= w_rsp.acc;
                        OP_SLP_A, OP_SLP_B: r_nums <= w_rsp.acc;
                        OP_ICP_A, OP_ICP_B: r_numi <= w_rsp.acc;
                        default:            r_numi <= w_rsp.acc;
                    endcase
                    if ((r_op == OP_ICP_B) && w_den_bad) begin
                        r_slope  <= '0;
                        r_icpt   <= '0;
                        r_status <= ST_ZERO_DEN;
                    end
                end
            end
            S_DIV_S: begin
                if (w_done) begin
                    r_slope <= w_rsp.quo;
                    r_sat   <= w_rsp.sat;
                end
            end
            S_DIV_I: begin
                if (w_done) begin
                    r_icpt <= w_rsp.quo;
                    if (r_dropped) begin
                        r_status <= ST_DROPPED;
                    end else if (r_sat || w_rsp.sat) begin
                        r_status <= ST_SATURATED;
                    end else begin
                        r_status <= ST_OK;
                    end
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_o_slope  <= r_slope;
                    r_o_icpt   <= r_icpt;
                    r_o_count  <= r_count;
                    r_o_status <= r_status;
                end
            end
            default: begin
                r_last <= r_last;
            end
        endcase
    end

    assign o_valid         = r_o_valid;
    assign o_fit_slope     = r_o_slope;
    assign o_fit_intercept = r_o_icpt;
    assign o_points_used   = r_o_count;
    assign o_fit_status    = r_o_status;

`ifndef NO_ASSERTIONS
    // A step is never issued while the unit is still working
    a_go_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.go |-> !w_rsp.busy)
        else $error("unit command while busy");

    // Completion only arrives for a step that was issued
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_wait)
        else $error("unit done without a pending step");

    // Zero denominator gives zero slope and intercept
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_fit_status == ST_ZERO_DEN)) |->
        ((o_fit_slope == '0) && (o_fit_intercept == '0)))
        else $error("nonzero fit on zero denominator");

    // Held count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_count <= CNT_W'(MAX_POINTS)))
        else $error("point count beyond capacity");
`endif

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for least_squares_line_fit_core: drives point sets through
// the valid/ready input, predicts each fit with exact wide arithmetic and checks
// every result item. Depends on lsf_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
    import lsf_pkg::*;

    localparam int LATENCY_WAIT = 600;

    typedef struct {
        logic signed [Q_W-1:0] slope;
        logic signed [Q_W-1:0] intercept;
        logic [CNT_W-1:0]      used;
        t_fit_status           status;
    } t_fit_result;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PERIODIC
    } t_ready_mode;

    localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
    localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic signed [SAMPLE_BITS-1:0] i_x_value = '0;
    logic signed [SAMPLE_BITS-1:0] i_y_value = '0;
    logic                          i_last_point = 1'b0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic signed [Q_W-1:0]         o_fit_slope;
    logic signed [Q_W-1:0]         o_fit_intercept;
    logic [CNT_W-1:0]              o_points_used;
    logic [1:0]                    o_fit_status;

    // Running sums of the point set being collected
    int          fit_n = 0;
    longint      fit_sx = 0;
    longint      fit_sy = 0;
    longint      fit_sxx = 0;
    longint      fit_sxy = 0;
    bit          fit_dropped = 1'b0;

    t_fit_result pending_fits[$];
    int          mismatch_count = 0;
    int          burst_left = 0;

    t_ready_mode ready_mode = RDY_ALWAYS;
    int          ready_left = 0;
    logic [4:0]  ready_tick = '0;

    least_squares_line_fit_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_x_value       (i_x_value),
        .i_y_value       (i_y_value),
        .i_last_point    (i_last_point),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_fit_slope     (o_fit_slope),
        .o_fit_intercept (o_fit_intercept),
        .o_points_used   (o_points_used),
        .o_fit_status    (o_fit_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #100_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // num * 2^16 / den, truncated toward zero; top bit flags saturation
    function automatic logic [Q_W:0] q16_quotient(input logic signed [127:0] num,
                                                  input logic signed [127:0] den);
        logic signed [127:0] quo;
        quo = (num * 128'sd65536) / den;
        if (quo > Q_MAX)
            return {1'b1, 32'h7FFF_FFFF};
        if (quo < Q_MIN)
            return {1'b1, 32'h8000_0000};
        return {1'b0, quo[Q_W-1:0]};
    endfunction

    // Fold one accepted point into the sums; on the last point queue the fit
    task automatic fold_point(input logic signed [SAMPLE_BITS-1:0] x,
                              input logic signed [SAMPLE_BITS-1:0] y,
                              input logic last);
        longint              xl;
        longint              yl;
        logic signed [127:0] w_n, w_sx, w_sy, w_sxx, w_sxy;
        logic signed [127:0] den, num_slope, num_icpt;
        logic [Q_W:0]        q_slope, q_icpt;
        t_fit_result         fit;
        xl = x;
        yl = y;
        if (fit_n < MAX_POINTS) begin
            fit_n++;
            fit_sx  += xl;
            fit_sy  += yl;
            fit_sxx += xl * xl;
            fit_sxy += xl * yl;
        end else begin
            fit_dropped = 1'b1;
        end
        if (last) begin
            w_n   = fit_n;
            w_sx  = fit_sx;
            w_sy  = fit_sy;
            w_sxx = fit_sxx;
            w_sxy = fit_sxy;
            den       = w_n * w_sxx - w_sx * w_sx;
            num_slope = w_n * w_sxy - w_sx * w_sy;
            num_icpt  = w_sy * w_sxx - w_sx * w_sxy;
            fit.used = fit_n[CNT_W-1:0];
            if (den <= 0) begin
                fit.slope     = '0;
                fit.intercept = '0;
                fit.status    = ST_ZERO_DEN;
            end else begin
                q_slope = q16_quotient(num_slope, den);
                q_icpt  = q16_quotient(num_icpt, den);
                fit.slope     = q_slope[Q_W-1:0];
                fit.intercept = q_icpt[Q_W-1:0];
                if (fit_dropped)
                    fit.status = ST_DROPPED;
                else if (q_slope[Q_W] || q_icpt[Q_W])
                    fit.status = ST_SATURATED;
                else
                    fit.status = ST_OK;
            end
            pending_fits.push_back(fit);
            fit_n       = 0;
            fit_sx      = 0;
            fit_sy      = 0;
            fit_sxx     = 0;
            fit_sxy     = 0;
            fit_dropped = 1'b0;
        end
    endtask

    // Send one point item; the sender runs in bursts with random gaps
    task automatic send_point(input logic signed [SAMPLE_BITS-1:0] x,
                              input logic signed [SAMPLE_BITS-1:0] y,
                              input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_x_value    <= x;
        i_y_value    <= y;
        i_last_point <= last;
        do @(posedge i_clk); while (!o_ready);
        fold_point(x, y, last);
    endtask

    // Hold off the sender until every queued fit has come back
    task automatic wait_for_fits();
        i_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_fits.size() != 0);
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 4))
            0: return -32768;
            1: return -1;
            2: return 0;
            3: return 1;
            default: return 32767;
        endcase
    endfunction

    // Directed sets: field extremes, zero denominator, saturation, rounding
    task automatic test_corner_sets();
        // lone point: zero denominator
        send_point(-16'sd32768, 16'sd32767, 1'b1);
        // all x equal: zero denominator
        send_point(16'sd5, 16'sd1, 1'b0);
        send_point(16'sd5, -16'sd3, 1'b0);
        send_point(16'sd5, 16'sd7, 1'b1);
        // slope beyond the Q16.16 range
        send_point(16'sd0, -16'sd32768, 1'b0);
        send_point(16'sd1, 16'sd32767, 1'b1);
        // steep line far right: slope and intercept both clamp, intercept low
        send_point(16'sd32766, -16'sd32768, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b1);
        // steep line far left: intercept clamps high
        send_point(-16'sd32767, -16'sd32768, 1'b0);
        send_point(-16'sd32766, 16'sd32767, 1'b1);
        // slope exactly at the negative end, no clamp
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd1, -16'sd32768, 1'b1);
        // negative fraction truncates toward zero
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd3, -16'sd1, 1'b1);
        // corners of the input range
        send_point(-16'sd32768, -16'sd32768, 1'b0);
        send_point(16'sd32767, 16'sd32767, 1'b0);
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(-16'sd1, 16'sd1, 1'b1);
    endtask

    // Random point sets, about half of them noisy lines, with degenerate sets mixed in
    task automatic test_random_sets(input int item_budget);
        int sent;
        int len;
        int kind;
        int slope_k;
        int offset;
        int x_base;
        int x_span;
        int x_fixed;
        int xi;
        int yi;
        int i;
        sent = 0;
        while (sent < item_budget) begin
            kind = $urandom_range(0, 9);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(2, 12);
            if (kind == 8)
                len = 1;
            slope_k = int'($urandom_range(0, 8000)) - 4000;
            offset  = int'($urandom_range(0, 4000)) - 2000;
            x_base  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                                   : int'($urandom_range(0, 4000)) - 2000;
            x_span  = $urandom_range(1, 2000);
            x_fixed = int'($urandom_range(0, 65535)) - 32768;
            for (i = 0; i < len; i++) begin
                case (kind)
                    0, 1, 2, 3, 4: begin
                        // noisy line y = slope_k/16 * x + offset
                        xi = x_base + int'($urandom_range(0, x_span));
                        if (xi > 32767)
                            xi = 32767;
                        yi = (slope_k * xi) / 16 + offset + int'($urandom_range(0, 16)) - 8;
                        if (yi > 32767)
                            yi = 32767;
                        else if (yi < -32768)
                            yi = -32768;
                    end
                    7: begin
                        // vertical set
                        xi = x_fixed;
                        yi = $urandom;
                    end
                    9: begin
                        xi = pick_extreme();
                        yi = pick_extreme();
                    end
                    default: begin
                        xi = $urandom;
                        yi = $urandom;
                    end
                endcase
                send_point(16'(xi), 16'(yi), i == len - 1);
            end
            sent += len;
        end
    endtask

    // Overfill one set: the last two points are dropped, the final one still ends the set with a fit
    task automatic test_capacity();
        int i;
        for (i = 0; i < MAX_POINTS + 1; i++)
            send_point(16'($urandom), 16'($urandom), 1'b0);
        send_point(16'($urandom), 16'($urandom), 1'b1);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin : check_fit
        t_fit_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_fits.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result item with none expected, slope %0d intercept %0d",
                             $realtime, o_fit_slope, o_fit_intercept);
            end else begin
                want = pending_fits.pop_front();
                check_field("fit_slope", want.slope, o_fit_slope);
                check_field("fit_intercept", want.intercept, o_fit_intercept);
                check_field("points_used", want.used, o_points_used);
                check_field("fit_status", want.status, o_fit_status);
            end
        end
    end

    // Receiver stalls: always ready, random, or a long periodic stall
    always @(posedge i_clk) begin
        ready_tick <= ready_tick + 1'b1;
        if (ready_left == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 2));
            ready_left <= $urandom_range(20, 200);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            RDY_ALWAYS:   i_ready <= 1'b1;
            RDY_RANDOM:   i_ready <= ($urandom_range(0, 3) != 0);
            default:      i_ready <= (ready_tick >= 5'd24);
        endcase
    end

    // Test sequence
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_sets();
        wait_for_fits();
        test_random_sets(700);
        wait_for_fits();
        test_capacity();
        wait_for_fits();
        test_random_sets(730);
        wait_for_fits();
        repeat (LATENCY_WAIT) @(posedge i_clk);
        if (pending_fits.size() != 0)
            $display("%0d expected results never arrived", pending_fits.size());
        if (mismatch_count == 0 && pending_fits.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
